// ===== sv/arpc_pkg.sv =====
// shared types and constants for the arp cache with aging
package arpc_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int AGE_BITS      = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int IP_W          = 32;
   localparam int MAC_W         = 48;
   localparam int SLOT_W        = 4;
   localparam int KIND_W        = 2;

   localparam logic [KIND_W-1:0] KIND_LEARN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam logic [AGE_BITS-1:0] AGE_FULL = '1;
   localparam logic [IDX_W-1:0]    IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

   typedef struct packed {
      logic [KIND_W-1:0] req_type;
      logic [IP_W-1:0]   ip_addr;
      logic [MAC_W-1:0]  mac_addr;
   } arpc_req_type;

   typedef struct packed {
      logic              found;
      logic [MAC_W-1:0]  mac_out;
      logic [SLOT_W-1:0] slot;
   } arpc_rsp_type;

   typedef struct packed {
      logic [IP_W-1:0]     ip;
      logic [MAC_W-1:0]    mac;
      logic [AGE_BITS-1:0] age;
   } arpc_entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      arpc_entry_type   entry;
   } arpc_wr_type;

endpackage

// ===== sv/arpc_store.sv =====
// entry memory with per-entry valid bits, one registered read port and one write port
module arpc_store (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [arpc_pkg::IDX_W-1:0]     rd_addr,
   output arpc_pkg::arpc_entry_type       rd_entry,
   input  arpc_pkg::arpc_wr_type          wr
);
   import arpc_pkg::*;

   arpc_entry_type              mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]    vld_ff;
   arpc_entry_type              rd_data_ff;
   logic                        rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // never-written entries read as cleared
   assign rd_entry = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== sv/arp_cache_with_aging_unit.sv =====
// top level of the arp cache with aging
// Address cache of TABLE_ENTRIES entries mapping protocol to hardware addresses. Each
// request beat (learn, lookup or aging tick) walks the whole table through the single
// read port of the entry memory, one entry per cycle, then does the learn write-back
// and forms the result; an unused request code answers without a walk. Tick
// write-backs ride along with the walk. One request is in flight at a time: the next
// beat is accepted the cycle after the result beat is taken. After reset every entry
// reads as zero with no clearing pass.
module arp_cache_with_aging_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  arpc_pkg::arpc_req_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output arpc_pkg::arpc_rsp_type  rsp_data
);
   import arpc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE, S_RESP} state_type;

   state_type            state_ff, state_in;
   arpc_req_type         req_ff, req_in;
   logic [IDX_W-1:0]     iss_ff, iss_in;
   logic                 iss_done_ff, iss_done_in;
   logic                 chk_ff, chk_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [MAC_W-1:0]     hit_mac_ff, hit_mac_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [AGE_BITS-1:0]  best_age_ff, best_age_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   arpc_rsp_type         rsp_ff, rsp_in;

   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   arpc_entry_type       rd_entry;
   arpc_wr_type          wr;
   logic [IDX_W-1:0]     learn_idx;

   arpc_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   assign learn_idx = hit_ff ? hit_idx_ff : best_idx_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      iss_in       = iss_ff;
      iss_done_in  = iss_done_ff;
      chk_in       = 1'b0;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_mac_in   = hit_mac_ff;
      best_idx_in  = best_idx_ff;
      best_age_in  = best_age_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = iss_ff;
      wr           = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               iss_in      = '0;
               iss_done_in = 1'b0;
               hit_in      = 1'b0;
               hit_idx_in  = '0;
               hit_mac_in  = '0;
               best_idx_in = '0;
               best_age_in = '0;
               if (req_data.req_type == KIND_UNUSED) begin
                  rsp_in       = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (!iss_done_ff) begin
               rd_en      = 1'b1;
               chk_in     = 1'b1;
               chk_idx_in = iss_ff;
               if (iss_ff == IDX_LAST) begin
                  iss_done_in = 1'b1;
               end else begin
                  iss_in = iss_ff + 1'b1;
               end
            end
            if (chk_ff) begin
               // first match wins
               if (!hit_ff && rd_entry.ip == req_ff.ip_addr) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk_idx_ff;
                  hit_mac_in = rd_entry.mac;
               end
               // smallest age, lowest index on ties
               if (chk_idx_ff == '0 || rd_entry.age < best_age_ff) begin
                  best_idx_in = chk_idx_ff;
                  best_age_in = rd_entry.age;
               end
               if (req_ff.req_type == KIND_TICK && rd_entry.age != '0) begin
                  wr.en        = 1'b1;
                  wr.addr      = chk_idx_ff;
                  wr.entry.ip  = rd_entry.ip;
                  wr.entry.mac = rd_entry.mac;
                  wr.entry.age = AGE_BITS'(rd_entry.age - 1'b1);
               end
               if (chk_idx_ff == IDX_LAST) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            rsp_in = '0;
            case (req_ff.req_type)
               KIND_LEARN: begin
                  wr.en        = 1'b1;
                  wr.addr      = learn_idx;
                  wr.entry.ip  = req_ff.ip_addr;
                  wr.entry.mac = req_ff.mac_addr;
                  wr.entry.age = AGE_FULL;
                  rsp_in.found = hit_ff;
                  rsp_in.slot  = SLOT_W'(learn_idx);
               end
               KIND_LOOKUP: begin
                  rsp_in.found   = hit_ff;
                  rsp_in.mac_out = hit_mac_ff;
                  rsp_in.slot    = SLOT_W'(hit_idx_ff);
               end
               default: begin
                  rsp_in = '0;
               end
            endcase
            rsp_valid_in = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         chk_ff       <= 1'b0;
         iss_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_ff       <= chk_in;
         iss_done_ff  <= iss_done_in;
      end
      req_ff      <= req_in;
      iss_ff      <= iss_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_mac_ff  <= hit_mac_in;
      best_idx_ff <= best_idx_in;
      best_age_ff <= best_age_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid_ff))
      else $error("request taken while a result beat is pending");

   a_wr_window: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == S_SCAN || state_ff == S_DONE))
      else $error("store written outside scan or write-back");

   a_tick_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (req_ff.req_type == KIND_TICK || req_ff.req_type == KIND_UNUSED))
      |-> (rsp_ff == '0))
      else $error("tick or unused code gave a nonzero result");

   a_miss_mac: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.mac_out == '0))
      else $error("miss carries a hardware address");

   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (iss_done_ff && !chk_ff))
      else $error("write-back reached with scan reads outstanding");

endmodule

// ===== tb/sv/tb_arp_cache_with_aging_unit.sv =====
// self-checking testbench for the arp cache with aging: directed and random requests
module tb_arp_cache_with_aging_unit;
   import arpc_pkg::*;

   localparam int POOL_SIZE     = 24;
   localparam int LONG_HOLD_AT  = 60;
   localparam int LONG_HOLD     = 150;
   localparam int PHASE_ITEMS   = 132;

   logic         clock;
   logic         reset;
   logic         req_valid = 1'b0;
   logic         req_ready;
   arpc_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   arpc_rsp_type rsp_data;

   arpc_req_type pending_reqs[$];
   arpc_rsp_type expected_rsps[$];

   logic [IP_W-1:0]     ip_tab  [TABLE_ENTRIES] = '{default: '0};
   logic [MAC_W-1:0]    mac_tab [TABLE_ENTRIES] = '{default: '0};
   logic [AGE_BITS-1:0] age_tab [TABLE_ENTRIES] = '{default: '0};
   logic [IP_W-1:0]     ip_pool [POOL_SIZE];

   int gap_max    = 17;
   int send_gap   = 0;
   int hold_left  = 0;
   int rsp_count  = 0;
   int errors     = 0;
   int kind_count [4] = '{default: 0};
   int learn_refresh = 0;
   int lookup_hits   = 0;

   arp_cache_with_aging_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1600000;
      $display("arp_cache_with_aging_unit: mismatch");
      $finish;
   end

   function automatic arpc_rsp_type cache_apply(arpc_req_type r);
      arpc_rsp_type res;
      int hit;
      int victim;
      res = '0;
      hit = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (hit < 0 && ip_tab[i] == r.ip_addr) hit = i;
      kind_count[r.req_type]++;
      case (r.req_type)
         KIND_LEARN: begin
            if (hit >= 0) begin
               res.found = 1'b1;
               learn_refresh++;
            end else begin
               victim = 0;
               for (int i = 1; i < TABLE_ENTRIES; i++)
                  if (age_tab[i] < age_tab[victim]) victim = i;
               hit = victim;
               ip_tab[hit] = r.ip_addr;
            end
            mac_tab[hit] = r.mac_addr;
            age_tab[hit] = AGE_FULL;
            res.slot = SLOT_W'(hit);
         end
         KIND_LOOKUP: begin
            if (hit >= 0) begin
               res.found   = 1'b1;
               res.mac_out = mac_tab[hit];
               res.slot    = SLOT_W'(hit);
               lookup_hits++;
            end
         end
         KIND_TICK: begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (age_tab[i] != '0) age_tab[i] = age_tab[i] - 1'b1;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic check_rsp(arpc_rsp_type got);
      arpc_rsp_type want;
      if (expected_rsps.size() == 0) begin
         $error("result beat with no request outstanding");
         errors++;
         return;
      end
      want = expected_rsps.pop_front();
      if (got.found !== want.found) begin
         $error("found: expected %0h, actual %0h", want.found, got.found);
         errors++;
      end
      if (got.mac_out !== want.mac_out) begin
         $error("mac_out: expected %0h, actual %0h", want.mac_out, got.mac_out);
         errors++;
      end
      if (got.slot !== want.slot) begin
         $error("slot: expected %0h, actual %0h", want.slot, got.slot);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_rsps.push_back(cache_apply(req_data));
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending_reqs.size() != 0) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               send_gap  <= $urandom_range(0, gap_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_side
      int hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         check_rsp(rsp_data);
         rsp_count <= rsp_count + 1;
         hold = (rsp_count + 1 == LONG_HOLD_AT) ? LONG_HOLD : $urandom_range(0, gap_max);
         hold_left <= hold;
         rsp_ready <= (hold == 0);
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic add_req(logic [KIND_W-1:0] kind, logic [IP_W-1:0] ip,
                          logic [MAC_W-1:0] mac);
      arpc_req_type r;
      r.req_type = kind;
      r.ip_addr  = ip;
      r.mac_addr = mac;
      pending_reqs.push_back(r);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
   endtask

   function automatic logic [MAC_W-1:0] random_mac();
      return MAC_W'({$urandom(), $urandom()});
   endfunction

   function automatic arpc_req_type random_req();
      arpc_req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r.mac_addr = random_mac();
      r.ip_addr  = (pick % 10 == 0) ? $urandom() : ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 40)      r.req_type = KIND_LEARN;
      else if (pick < 75) r.req_type = KIND_LOOKUP;
      else if (pick < 94) r.req_type = KIND_TICK;
      else                r.req_type = KIND_UNUSED;
      return r;
   endfunction

   initial begin
      reset = 1'b1;
      ip_pool[0] = '0;
      ip_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // cleared entries match address zero
      add_req(KIND_LOOKUP, 32'h0, 48'h0);
      add_req(KIND_LOOKUP, 32'hFFFF_FFFF, 48'h0);
      add_req(KIND_LEARN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      add_req(KIND_LOOKUP, 32'hFFFF_FFFF, random_mac());
      add_req(KIND_LEARN, 32'h0, 48'h0);
      add_req(KIND_TICK, $urandom(), random_mac());
      add_req(KIND_UNUSED, $urandom(), random_mac());
      for (int i = 0; i < 14; i++)
         add_req(KIND_LEARN, 32'h0A00_0001 + i, random_mac());
      add_req(KIND_LOOKUP, 32'h0A00_000E, 48'h0);
      // full table: oldest entries lose on age, lowest index on ties
      add_req(KIND_LEARN, 32'hC0A8_0001, random_mac());
      add_req(KIND_TICK, 32'h0, 48'h0);
      add_req(KIND_LEARN, 32'hC0A8_0002, random_mac());
      wait_idle();

      for (int p = 0; p < 4; p++) begin
         gap_max <= (p == 0 || p == 2) ? 0 : 17;
         for (int i = 0; i < PHASE_ITEMS; i++) pending_reqs.push_back(random_req());
         wait_idle();
      end

      repeat (40) @(posedge clock);
      $display("%0d results: %0d learns (%0d refreshed), %0d lookups (%0d hits),",
               rsp_count, kind_count[KIND_LEARN], learn_refresh,
               kind_count[KIND_LOOKUP], lookup_hits);
      $display("%0d aging ticks, %0d unused codes, one long result stall, mixed idling",
               kind_count[KIND_TICK], kind_count[KIND_UNUSED]);
      if (errors == 0) begin
         $display("arp_cache_with_aging_unit: match");
      end else begin
         $display("arp_cache_with_aging_unit: mismatch");
      end
      $finish;
   end

endmodule
